[rtl/core/ffgv_pkg.sv]
// Shared types and constants for the flood fill grid verifier.
// No dependencies; used by every module under rtl/core.
`default_nettype none
package ffgv_pkg;
  localparam int DimBits = 6;
  localparam int DimMax  = 32;
  localparam logic [DimBits-1:0] RowsReset = 6'd32;
  localparam logic [DimBits-1:0] ColsReset = 6'd32;
  localparam logic RegRows = 1'b0;
  localparam logic RegCols = 1'b1;
endpackage
`default_nettype wire

[rtl/core/flood_fill_grid_verify.sv]
// Top level of the flood fill grid verifier: loader, fill engine, checker.
// Depends on ffgv_pkg and contains the grid, visited and queue memories.
//
// Channel | Direction | Signals
// in      | input     | in_valid/in_ready, before_value, after_value, last_cell
// out     | output    | out_valid/out_ready, reachable
// cfg     | input     | cfg_we, cfg_index, cfg_wdata
//
// Items are taken while in the load state. After the last item a sequencer
// scans for the first differing cell (reporting reachable if none differs),
// clears the whole visited map, runs the fill (pop a cell, paint it, then for
// each of four directions read an in-grid neighbor and queue it if unvisited
// and matching; each memory has a single port), and compares the grid cell by
// cell. Reset is synchronous; the result register holds while out_ready is low
// and no item is taken until the result leaves.
`default_nettype none
module flood_fill_grid_verify #(
  parameter int MAX_ROWS   = 32,
  parameter int MAX_COLS   = 32,
  parameter int VALUE_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [9:0]            in_before_value,
  input  wire logic [9:0]            in_after_value,
  input  wire logic                  in_last_cell,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_reachable,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [5:0]            cfg_wdata
);
  localparam int Cells = MAX_ROWS * MAX_COLS;
  localparam int AW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int QW = RW + CW;
  localparam int VW = (VALUE_BITS < 10) ? VALUE_BITS : 10;

  typedef enum logic [4:0] {
    S_LOAD, S_SCAN_RD, S_SCAN_CMP, S_CLR, S_SEED, S_SEED_W,
    S_POP_RD, S_POP_WAIT, S_PAINT, S_NB, S_NB_RD, S_NB_CHK,
    S_CHK_RD, S_CHK_CMP, S_DONE
  } state_t;

  state_t state_r;
  logic [5:0] rows_r, cols_r;
  logic [AW:0] pos_r, idx_r, head_r, tail_r;
  logic [AW-1:0] cur_r, nb_r;
  logic [RW-1:0] cr_r, scan_row_r;
  logic [CW-1:0] cc_r, scan_col_r;
  logic [1:0] dir_r;
  logic [VALUE_BITS-1:0] match_r, paint_r;
  logic res_r, outv_r;

  logic [VALUE_BITS-1:0] orig_mem [Cells];
  logic [VALUE_BITS-1:0] des_mem [Cells];
  logic visit_mem [Cells];
  logic [QW-1:0] queue_mem [Cells];
  logic [VALUE_BITS-1:0] orig_q, des_q;
  logic visit_q;
  logic [QW-1:0] queue_q;

  // Clamped dimensions and cell count.
  logic [8:0] nr, nc;
  logic [AW:0] total;
  always_comb begin
    nr = (rows_r == 6'd0) ? 9'd1 : ({3'd0, rows_r} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {3'd0, rows_r};
    nc = (cols_r == 6'd0) ? 9'd1 : ({3'd0, cols_r} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {3'd0, cols_r};
    total = (AW+1)'(nr * nc);
  end

  // Memory port controls.
  logic o_we, d_we, v_we, q_we;
  logic [AW-1:0] o_a, d_a, v_a, q_a;
  logic [VALUE_BITS-1:0] o_wd, d_wd;
  logic v_wd;
  logic [QW-1:0] q_wd;

  // Neighbor candidate from current cell and direction.
  logic nb_ok;
  logic [RW:0] nrr;
  logic [CW:0] ncc;
  always_comb begin
    nrr = {1'b0, cr_r};
    ncc = {1'b0, cc_r};
    nb_ok = 1'b0;
    unique case (dir_r)
      2'd0: begin nrr = nrr + 1'b1; nb_ok = (9'(nrr) < nr); end
      2'd1: begin nrr = nrr - 1'b1; nb_ok = (cr_r != '0); end
      2'd2: begin ncc = ncc + 1'b1; nb_ok = (9'(ncc) < nc); end
      default: begin ncc = ncc - 1'b1; nb_ok = (cc_r != '0); end
    endcase
  end
  logic [AW-1:0] nb_addr;
  assign nb_addr = AW'(AW'(nrr) * AW'(nc) + AW'(ncc));

  // Queue entries hold row and column, so no division is needed on a pop.
  always_comb begin
    o_we = 1'b0; d_we = 1'b0; v_we = 1'b0; q_we = 1'b0;
    o_a = idx_r[AW-1:0]; d_a = idx_r[AW-1:0]; v_a = idx_r[AW-1:0]; q_a = head_r[AW-1:0];
    o_wd = VALUE_BITS'(in_before_value[VW-1:0]);
    d_wd = VALUE_BITS'(in_after_value[VW-1:0]);
    v_wd = 1'b0; q_wd = {cr_r, cc_r};
    unique case (state_r)
      S_LOAD: begin
        o_a = pos_r[AW-1:0]; d_a = pos_r[AW-1:0];
        if (in_valid && in_ready && pos_r < total) begin o_we = 1'b1; d_we = 1'b1; end
      end
      S_CLR: v_we = 1'b1;
      S_SEED: begin
        v_a = cur_r; v_we = 1'b1; v_wd = 1'b1;
        q_a = '0; q_we = 1'b1;
      end
      S_PAINT: begin o_a = cur_r; o_we = 1'b1; o_wd = paint_r; end
      S_NB_RD: begin o_a = nb_r; v_a = nb_r; end
      S_NB_CHK: begin
        v_a = nb_r; q_a = tail_r[AW-1:0]; q_wd = {nrr[RW-1:0], ncc[CW-1:0]};
        if (!visit_q && orig_q == match_r && tail_r < (AW+1)'(Cells)) begin
          v_we = 1'b1; v_wd = 1'b1; q_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (o_we) orig_mem[o_a] <= o_wd;
    orig_q <= orig_mem[o_a];
    if (d_we) des_mem[d_a] <= d_wd;
    des_q <= des_mem[d_a];
    if (v_we) visit_mem[v_a] <= v_wd;
    visit_q <= visit_mem[v_a];
    if (q_we) queue_mem[q_a] <= q_wd;
    queue_q <= queue_mem[q_a];
  end

  assign in_ready = (state_r == S_LOAD);
  assign out_valid = outv_r;
  assign out_reachable = res_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; rows_r <= ffgv_pkg::RowsReset; cols_r <= ffgv_pkg::ColsReset;
      pos_r <= '0; idx_r <= '0; head_r <= '0; tail_r <= '0;
      outv_r <= 1'b0; res_r <= 1'b0; dir_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ffgv_pkg::RegRows) rows_r <= cfg_wdata;
        else cols_r <= cfg_wdata;
      end
      unique case (state_r)
        S_LOAD: if (in_valid) begin
          if (pos_r < total) pos_r <= pos_r + 1'b1;
          if (in_last_cell) begin
            pos_r <= '0; idx_r <= '0; state_r <= S_SCAN_RD;
            scan_row_r <= '0; scan_col_r <= '0;
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (orig_q != des_q) begin
            cur_r <= idx_r[AW-1:0]; match_r <= orig_q; paint_r <= des_q;
            cr_r <= scan_row_r; cc_r <= scan_col_r;
            idx_r <= '0; state_r <= S_CLR;
          end else if (idx_r + 1'b1 >= total) begin
            res_r <= 1'b1; outv_r <= 1'b1; state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1; state_r <= S_SCAN_RD;
            // Track row and column of the scan position.
            if (9'(scan_col_r) + 9'd1 >= nc) begin
              scan_col_r <= '0; scan_row_r <= scan_row_r + 1'b1;
            end else begin
              scan_col_r <= scan_col_r + 1'b1;
            end
          end
        end
        S_CLR: begin
          if (idx_r + 1'b1 >= (AW+1)'(Cells)) state_r <= S_SEED;
          idx_r <= idx_r + 1'b1;
        end
        S_SEED: begin head_r <= '0; tail_r <= (AW+1)'(1); state_r <= S_POP_RD; end
        S_POP_RD: begin
          if (head_r < tail_r && head_r < (AW+1)'(Cells)) state_r <= S_POP_WAIT;
          else begin idx_r <= '0; state_r <= S_CHK_RD; end
        end
        S_POP_WAIT: begin
          head_r <= head_r + 1'b1;
          cr_r <= queue_q[QW-1:CW]; cc_r <= queue_q[CW-1:0];
          cur_r <= AW'(AW'(queue_q[QW-1:CW]) * AW'(nc) + AW'(queue_q[CW-1:0]));
          state_r <= S_PAINT;
        end
        S_PAINT: begin dir_r <= '0; state_r <= S_NB; end
        S_NB: begin
          if (nb_ok) begin nb_r <= nb_addr; state_r <= S_NB_RD; end
          else if (dir_r == 2'd3) state_r <= S_POP_RD;
          else dir_r <= dir_r + 1'b1;
        end
        S_NB_RD: state_r <= S_NB_CHK;
        S_NB_CHK: begin
          if (!visit_q && orig_q == match_r && tail_r < (AW+1)'(Cells)) tail_r <= tail_r + 1'b1;
          if (dir_r == 2'd3) state_r <= S_POP_RD;
          else begin dir_r <= dir_r + 1'b1; state_r <= S_NB; end
        end
        S_CHK_RD: state_r <= S_CHK_CMP;
        S_CHK_CMP: begin
          if (orig_q != des_q) begin
            res_r <= 1'b0; outv_r <= 1'b1; state_r <= S_DONE;
          end else if (idx_r + 1'b1 >= total) begin
            res_r <= 1'b1; outv_r <= 1'b1; state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1; state_r <= S_CHK_RD;
          end
        end
        S_DONE: if (out_ready) begin outv_r <= 1'b0; state_r <= S_LOAD; end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

[dv/tb_flood_fill_grid_verify.sv]
// Self-checking testbench for flood_fill_grid_verify: streams grids of cells
// and checks each reachable result against a flood fill predictor kept here.
// Depends on ffgv_pkg and the flood_fill_grid_verify RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_flood_fill_grid_verify;

  localparam int Cells      = 1024;
  localparam int WatchLimit = 200000;

  typedef struct packed {
    logic [9:0] before_value;
    logic [9:0] after_value;
    logic       last_cell;
  } cell_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [9:0]       in_before_value = '0;
  logic [9:0]       in_after_value = '0;
  logic             in_last_cell = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_reachable;
  logic             cfg_we = 1'b0;
  logic             cfg_index = ffgv_pkg::RegRows;
  logic [ffgv_pkg::DimBits-1:0] cfg_wdata = '0;

  cell_item_t pending_cells[$];
  logic       expected_reachable[$];
  int         mismatch_count = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;

  // Predictor state.
  logic [9:0] grid_before[Cells];
  logic [9:0] grid_after[Cells];
  int         load_pos = 0;
  int         rows_reg = 32;
  int         cols_reg = 32;

  // Scratch for the breadth-first fill, shared by predictor and generator.
  logic [9:0] work_grid[Cells];
  bit         seen[Cells];
  int         fill_q[Cells];
  int         step_r[4] = '{1, -1, 0, 0};
  int         step_c[4] = '{0, 0, 1, -1};

  // Generator bookkeeping.
  logic [9:0] gen_before[Cells];
  logic [9:0] gen_after[Cells];
  bit         gen_written[Cells];

  flood_fill_grid_verify DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_before_value(in_before_value), .in_after_value(in_after_value),
    .in_last_cell(in_last_cell),
    .out_valid(out_valid), .out_ready(out_ready), .out_reachable(out_reachable),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int clamp_dim(int raw);
    if (raw < 1) return 1;
    if (raw > ffgv_pkg::DimMax) return ffgv_pkg::DimMax;
    return raw;
  endfunction

  // Mostly short gaps, now and then a long one; none during calm phases.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Breadth-first 4-connected fill of work_grid from start with paint.
  function automatic void flood_region(int start, int nr, int nc, logic [9:0] paint);
    int head, tail, cur, r, c, rr, cc, nb;
    logic [9:0] match;
    match = work_grid[start];
    for (int i = 0; i < Cells; i++) seen[i] = 1'b0;
    head = 0;
    tail = 0;
    fill_q[tail++] = start;
    seen[start] = 1'b1;
    while (head < tail) begin
      cur = fill_q[head++];
      r = cur / nc;
      c = cur % nc;
      work_grid[cur] = paint;
      for (int d = 0; d < 4; d++) begin
        rr = r + step_r[d];
        cc = c + step_c[d];
        if (rr < 0 || cc < 0 || rr >= nr || cc >= nc) continue;
        nb = rr * nc + cc;
        if (!seen[nb] && work_grid[nb] == match) begin
          seen[nb] = 1'b1;
          fill_q[tail++] = nb;
        end
      end
    end
  endfunction

  // Loads one cell; returns -1 when no result, else the reachable bit.
  function automatic int predict_cell(cell_item_t it);
    int nr, nc, total, start;
    nr = clamp_dim(rows_reg);
    nc = clamp_dim(cols_reg);
    total = nr * nc;
    if (load_pos < total) begin
      grid_before[load_pos] = it.before_value;
      grid_after[load_pos] = it.after_value;
      load_pos++;
    end
    if (!it.last_cell) return -1;
    load_pos = 0;
    start = -1;
    for (int i = 0; i < total; i++)
      if (start < 0 && grid_before[i] != grid_after[i]) start = i;
    if (start >= 0) begin
      for (int i = 0; i < total; i++) work_grid[i] = grid_before[i];
      flood_region(start, nr, nc, grid_after[start]);
      for (int i = 0; i < total; i++) grid_before[i] = work_grid[i];
    end
    for (int i = 0; i < total; i++)
      if (grid_before[i] != grid_after[i]) return 0;
    return 1;
  endfunction

  // Builds one grid and queues len cells of it; extra cells beyond the grid
  // are dropped by the block, fewer cells leave earlier contents in place.
  task automatic queue_grid(int nr, int nc, int len);
    int total, npal, mode, cnt;
    logic [9:0] pal[3];
    cell_item_t it;
    total = nr * nc;
    npal = $urandom_range(1, 3);
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0: pal[k] = 10'd0;
        1: pal[k] = 10'd1023;
        default: pal[k] = 10'($urandom_range(0, 1023));
      endcase
    end
    for (int i = 0; i < total; i++) begin
      gen_before[i] = pal[$urandom_range(0, npal - 1)];
      work_grid[i] = gen_before[i];
    end
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      for (int i = 0; i < total; i++) gen_after[i] = gen_before[i];
    end else if (mode == 1) begin
      for (int i = 0; i < total; i++) gen_after[i] = 10'($urandom_range(0, 1023));
    end else begin
      flood_region($urandom_range(0, total - 1), nr, nc,
                   ($urandom_range(0, 1) != 0) ? pal[$urandom_range(0, npal - 1)]
                                               : 10'($urandom_range(0, 1023)));
      for (int i = 0; i < total; i++) gen_after[i] = work_grid[i];
      if (mode == 2) gen_after[$urandom_range(0, total - 1)] = 10'($urandom_range(0, 1023));
    end
    for (int i = 0; i < len; i++) begin
      if (i < total) begin
        it.before_value = gen_before[i];
        it.after_value = gen_after[i];
        gen_written[i] = 1'b1;
      end else begin
        it.before_value = 10'($urandom_range(0, 1023));
        it.after_value = 10'($urandom_range(0, 1023));
      end
      it.last_cell = (i == len - 1);
      pending_cells.push_back(it);
    end
  endtask

  // Picks a cell count: usually the full grid, sometimes short or too long.
  function automatic int pick_length(int total);
    int len;
    bit ok;
    len = total;
    case ($urandom_range(0, 9))
      0: len = total + $urandom_range(1, 4);
      1, 2: begin
        len = $urandom_range(1, total);
        ok = 1'b1;
        for (int i = len; i < total; i++) if (!gen_written[i]) ok = 1'b0;
        if (!ok) len = total;
      end
      default: len = total;
    endcase
    return len;
  endfunction

  task automatic write_reg(logic idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[ffgv_pkg::DimBits-1:0];
    if (idx == ffgv_pkg::RegRows) rows_reg = val & 63;
    else cols_reg = val & 63;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_cells.size() != 0 || in_valid || expected_reachable.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Driver: presents the next queued item once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cells.size() != 0) begin
        cell_item_t it;
        it = pending_cells.pop_front();
        in_valid <= 1'b1;
        in_before_value <= it.before_value;
        in_after_value <= it.after_value;
        in_last_cell <= it.last_cell;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted item and checks each result.
  always @(posedge clk) begin
    int pred;
    logic want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pred = predict_cell('{in_before_value, in_after_value, in_last_cell});
        if (pred >= 0) expected_reachable.push_back(pred[0]);
      end
      if (out_valid && out_ready) begin
        if (expected_reachable.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: reachable=%0b", out_reachable);
        end else begin
          want = expected_reachable.pop_front();
          if (out_reachable !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("reachable mismatch: expected %0b, got %0b", want, out_reachable);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("** flood_fill_grid_verify: FAILED **");
      $finish;
    end
  end

  // Phases: directed dimension corners first, then random small grids.
  initial begin
    int dir_rows[7] = '{1, 0, 63, 32, 1, 2, 5};
    int dir_cols[7] = '{1, 0, 1, 32, 40, 2, 3};
    int nr, nc, sent, phase_items;
    sent = 0;
    for (int i = 0; i < Cells; i++) gen_written[i] = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; sent < 1550; phase++) begin
      if (phase < 7) begin
        write_reg(ffgv_pkg::RegRows, dir_rows[phase]);
        write_reg(ffgv_pkg::RegCols, dir_cols[phase]);
      end else begin
        write_reg(ffgv_pkg::RegRows, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
        write_reg(ffgv_pkg::RegCols, $urandom_range(1, 9));
      end
      calm = (phase % 4 == 1);
      nr = clamp_dim(rows_reg);
      nc = clamp_dim(cols_reg);
      if (phase == 3) begin
        // One full-size grid, then a short grid over its leftover cells.
        queue_grid(nr, nc, nr * nc);
        queue_grid(nr, nc, 7);
        sent += nr * nc + 7;
      end else begin
        phase_items = 0;
        while (phase_items < ((phase < 3) ? 3 : 40)) begin
          int len;
          len = pick_length(nr * nc);
          queue_grid(nr, nc, len);
          phase_items += len;
        end
        sent += phase_items;
      end
      wait_drained();
    end
    if (mismatch_count == 0 && expected_reachable.size() == 0)
      $display("** flood_fill_grid_verify: PASSED **");
    else
      $display("** flood_fill_grid_verify: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
